/* rtl/core/wlg_pkg.sv */
// ----------------------------------------------------------------------------
// Watchdog relay package
// Types and constants shared by the watchdog relay modules.
// ----------------------------------------------------------------------------
package wlg_pkg;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_FEED = 2'd1,
        OP_LINK = 2'd2,
        OP_STOP = 2'd3
    } op_t;

    localparam int REG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [REG_IDX_BITS-1:0] REG_FEED_TIMEOUT = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SUPPLY_SECS = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_DETECT_SECS = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_LOOP_PERIOD = 2'd3;

    localparam logic [15:0] FEED_TIMEOUT_RST = 16'd150;
    localparam logic [7:0] SUPPLY_SECS_RST = 8'd60;
    localparam logic [7:0] DETECT_SECS_RST = 8'd30;
    localparam logic [9:0] LOOP_PERIOD_RST = 10'd100;

    // A window of (255 + 255) seconds in milliseconds fits in 19 bits.
    localparam int WIN_BITS = 19;
    localparam logic [WIN_BITS-1:0] MS_PER_SEC = 19'd1000;

    typedef struct packed {
        logic [15:0] feed_timeout_ms;
        logic [7:0] supply_secs;
        logic [7:0] detect_secs;
        logic [9:0] loop_period_ms;
    } cfg_t;

    typedef struct packed {
        logic feed_out;
        logic feed_missed;
        logic coms_lost;
        logic supplying;
    } result_t;

endpackage

/* rtl/core/wlg_cfg.sv */
// ----------------------------------------------------------------------------
// Watchdog relay configuration registers
// Holds the four setup registers and decodes the plain write port.
// ----------------------------------------------------------------------------
module wlg_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wlg_pkg::REG_IDX_BITS-1:0]    cfg_index,
    input  logic [wlg_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    output wlg_pkg::cfg_t                       cfg
);

    wlg_pkg::cfg_t cfg_reg;
    wlg_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                wlg_pkg::REG_FEED_TIMEOUT: cfg_next.feed_timeout_ms = cfg_wdata[15:0];
                wlg_pkg::REG_SUPPLY_SECS:  cfg_next.supply_secs = cfg_wdata[7:0];
                wlg_pkg::REG_DETECT_SECS:  cfg_next.detect_secs = cfg_wdata[7:0];
                wlg_pkg::REG_LOOP_PERIOD:  cfg_next.loop_period_ms = cfg_wdata[9:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.feed_timeout_ms <= wlg_pkg::FEED_TIMEOUT_RST;
            cfg_reg.supply_secs <= wlg_pkg::SUPPLY_SECS_RST;
            cfg_reg.detect_secs <= wlg_pkg::DETECT_SECS_RST;
            cfg_reg.loop_period_ms <= wlg_pkg::LOOP_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/wlg_core.sv */
// ----------------------------------------------------------------------------
// Watchdog relay state and evaluation
// Keeps the saturating ages, loop counter and flags, and computes the result
// of one request from the current state in a single pass.
// ----------------------------------------------------------------------------
module wlg_core #(
    parameter int AGE_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [1:0]          op,
    input  logic                link_ok,
    input  logic                stop_value,
    input  wlg_pkg::cfg_t       cfg,
    output wlg_pkg::result_t    res
);

    localparam int CMP_BITS = (AGE_BITS > wlg_pkg::WIN_BITS) ? AGE_BITS : wlg_pkg::WIN_BITS;

    logic [AGE_BITS-1:0] feed_age_reg;
    logic [AGE_BITS-1:0] feed_age_next;
    logic [AGE_BITS-1:0] loss_age_reg;
    logic [AGE_BITS-1:0] loss_age_next;
    logic [9:0] loop_count_reg;
    logic [9:0] loop_count_next;
    logic fed_once_reg;
    logic fed_once_next;
    logic stop_active_reg;
    logic stop_active_next;
    logic link_lost_reg;
    logic link_lost_next;
    logic supply_armed_reg;
    logic supply_armed_next;
    logic missed_flag_reg;
    logic missed_flag_next;

    logic [AGE_BITS-1:0] feed_inc;
    logic [AGE_BITS-1:0] loss_inc;
    logic [9:0] loop_inc;
    logic [8:0] secs_sum;
    logic [wlg_pkg::WIN_BITS-1:0] window_ms;
    logic [wlg_pkg::WIN_BITS-1:0] detect_ms;
    logic in_window;
    logic recent_feed;
    logic arm;
    logic feed;
    wlg_pkg::op_t op_code;

    assign op_code = wlg_pkg::op_t'(op);

    assign feed_inc = (&feed_age_reg) ? feed_age_reg : feed_age_reg + 1'b1;
    assign loss_inc = (&loss_age_reg) ? loss_age_reg : loss_age_reg + 1'b1;
    assign loop_inc = loop_count_reg + 10'd1;

    assign secs_sum = {1'b0, cfg.supply_secs} + {1'b0, cfg.detect_secs};
    assign window_ms = wlg_pkg::WIN_BITS'(secs_sum) * wlg_pkg::MS_PER_SEC;
    assign detect_ms = wlg_pkg::WIN_BITS'(cfg.detect_secs) * wlg_pkg::MS_PER_SEC;

    assign in_window = CMP_BITS'(loss_inc) < CMP_BITS'(window_ms);
    assign recent_feed = CMP_BITS'(feed_inc) <= CMP_BITS'(detect_ms);
    assign arm = supply_armed_reg || recent_feed;

    always_comb
    begin
        feed_age_next = feed_age_reg;
        loss_age_next = loss_age_reg;
        loop_count_next = loop_count_reg;
        fed_once_next = fed_once_reg;
        stop_active_next = stop_active_reg;
        link_lost_next = link_lost_reg;
        supply_armed_next = supply_armed_reg;
        missed_flag_next = missed_flag_reg;
        feed = 1'b0;
        case (op_code)
            wlg_pkg::OP_TICK:
            begin
                feed_age_next = feed_inc;
                loss_age_next = loss_inc;
                loop_count_next = loop_inc;
                if (loop_inc >= cfg.loop_period_ms)
                begin
                    loop_count_next = '0;
                    missed_flag_next = fed_once_reg &&
                        (CMP_BITS'(feed_inc) > CMP_BITS'(cfg.feed_timeout_ms));
                    if (link_lost_reg && in_window && !stop_active_reg)
                    begin
                        supply_armed_next = arm;
                        feed = arm;
                    end
                    if (!link_lost_reg)
                    begin
                        supply_armed_next = 1'b0;
                    end
                end
            end
            wlg_pkg::OP_FEED:
            begin
                if (!stop_active_reg)
                begin
                    fed_once_next = 1'b1;
                    feed_age_next = '0;
                    feed = 1'b1;
                end
            end
            wlg_pkg::OP_LINK:
            begin
                if (!fed_once_reg || link_ok)
                begin
                    link_lost_next = 1'b0;
                end
                else if (!link_lost_reg)
                begin
                    link_lost_next = 1'b1;
                    loss_age_next = '0;
                end
            end
            wlg_pkg::OP_STOP:
            begin
                stop_active_next = stop_value;
            end
            default:
            begin
                feed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_age_reg <= '1;
            loss_age_reg <= '1;
            loop_count_reg <= '0;
            fed_once_reg <= 1'b0;
            stop_active_reg <= 1'b0;
            link_lost_reg <= 1'b0;
            supply_armed_reg <= 1'b0;
            missed_flag_reg <= 1'b0;
        end
        else if (step)
        begin
            feed_age_reg <= feed_age_next;
            loss_age_reg <= loss_age_next;
            loop_count_reg <= loop_count_next;
            fed_once_reg <= fed_once_next;
            stop_active_reg <= stop_active_next;
            link_lost_reg <= link_lost_next;
            supply_armed_reg <= supply_armed_next;
            missed_flag_reg <= missed_flag_next;
        end
    end

    assign res.feed_out = feed;
    assign res.feed_missed = missed_flag_next;
    assign res.coms_lost = link_lost_next;
    assign res.supplying = supply_armed_next;

endmodule

/* rtl/core/watchdog_relay_with_loss_grace.sv */
// ----------------------------------------------------------------------------
// Watchdog relay with loss grace
// Top level: request register, state update and result register.
// ----------------------------------------------------------------------------
// The relay takes one request per clock cycle while the result side does not
// stall and returns exactly one result for each. A request is first held in
// an input register; once the output register is free or being taken, the
// state is updated and the result is written to the output register. Under
// back-pressure on the result side the output register holds its result and
// the input register can still be filled only while it is empty.
// Configuration registers are written through a plain write port and must be
// changed only while no request is in flight.
module watchdog_relay_with_loss_grace #(
    parameter int AGE_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          op,
    input  logic                                link_ok,
    input  logic                                stop_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                feed_out,
    output logic                                feed_missed,
    output logic                                coms_lost,
    output logic                                supplying,
    input  logic                                cfg_we,
    input  logic [wlg_pkg::REG_IDX_BITS-1:0]    cfg_index,
    input  logic [wlg_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    logic s1_valid_reg;
    logic s1_valid_next;
    logic [1:0] op_reg;
    logic link_ok_reg;
    logic stop_value_reg;
    logic out_valid_reg;
    logic out_valid_next;
    wlg_pkg::result_t res_reg;
    wlg_pkg::result_t res_comb;
    wlg_pkg::cfg_t cfg;
    logic in_fire;
    logic advance;

    assign advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg <= op;
            link_ok_reg <= link_ok;
            stop_value_reg <= stop_value;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    wlg_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cfg        (cfg)
    );

    wlg_core #(
        .AGE_BITS   (AGE_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .op         (op_reg),
        .link_ok    (link_ok_reg),
        .stop_value (stop_value_reg),
        .cfg        (cfg),
        .res        (res_comb)
    );

    assign out_valid = out_valid_reg;
    assign feed_out = res_reg.feed_out;
    assign feed_missed = res_reg.feed_missed;
    assign coms_lost = res_reg.coms_lost;
    assign supplying = res_reg.supplying;

endmodule

/* rtl/core/wlg_checker.sv */
// ----------------------------------------------------------------------------
// Watchdog relay port checker
// Watches the top-level ports for handshake and flow slips.
// ----------------------------------------------------------------------------
module wlg_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [1:0]                          op,
    input  logic                                link_ok,
    input  logic                                stop_value,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                feed_out,
    input  logic                                feed_missed,
    input  logic                                coms_lost,
    input  logic                                supplying,
    input  logic                                cfg_we,
    input  logic [wlg_pkg::REG_IDX_BITS-1:0]    cfg_index,
    input  logic [wlg_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    // A stalled result must stay offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result must keep its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(feed_out) && $stable(feed_missed)
            && $stable(coms_lost) && $stable(supplying))
        else $error("result payload changed while stalled");

    // With the result side empty, the relay must take a new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused while the result register is empty");

    // An accepted request yields a result when the result side does not stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
        else $error("accepted request produced no result");

endmodule

bind watchdog_relay_with_loss_grace wlg_checker u_wlg_checker (.*);
